### rtl/mi3_pkg.sv
package mi3_pkg;

   localparam int IN_WIDTH_DEF  = 16;
   localparam int OUT_WIDTH_DEF = 32;
   localparam int SCALE_SHIFT   = 28;
   localparam int NUM_ELEM      = 9;

   localparam int COF_LATENCY = 2;
   localparam int DET_LATENCY = 3;

endpackage

### rtl/mi3_cofactor.sv
module mi3_cofactor import mi3_pkg::*; #(
   parameter int IW = IN_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [IW-1:0]     a [NUM_ELEM],
   output logic                     out_valid,
   output logic signed [IW-1:0]     row1 [3],
   output logic signed [2*IW:0]     cof [NUM_ELEM]
);

   localparam int PW = 2 * IW;
   localparam int CW = 2 * IW + 1;

   logic                 v1_ff, v2_ff;
   logic signed [PW-1:0] p_ff [2*NUM_ELEM];
   logic signed [PW-1:0] p_in [2*NUM_ELEM];
   logic signed [IW-1:0] r1_ff [3];
   logic signed [IW-1:0] r2_ff [3];
   logic signed [CW-1:0] cof_ff [NUM_ELEM];

   // each cofactor is p[2i] - p[2i+1]
   always_comb begin
      p_in[0]  = a[4] * a[8];  p_in[1]  = a[5] * a[7];
      p_in[2]  = a[5] * a[6];  p_in[3]  = a[3] * a[8];
      p_in[4]  = a[3] * a[7];  p_in[5]  = a[4] * a[6];
      p_in[6]  = a[2] * a[7];  p_in[7]  = a[1] * a[8];
      p_in[8]  = a[0] * a[8];  p_in[9]  = a[2] * a[6];
      p_in[10] = a[1] * a[6];  p_in[11] = a[0] * a[7];
      p_in[12] = a[1] * a[5];  p_in[13] = a[2] * a[4];
      p_in[14] = a[2] * a[3];  p_in[15] = a[0] * a[5];
      p_in[16] = a[0] * a[4];  p_in[17] = a[1] * a[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      for (int i = 0; i < 3; i++) begin
         r1_ff[i] <= a[i];
         r2_ff[i] <= r1_ff[i];
      end
      for (int i = 0; i < NUM_ELEM; i++) begin
         cof_ff[i] <= CW'(p_ff[2*i]) - CW'(p_ff[2*i+1]);
      end
   end

   assign out_valid = v2_ff;
   assign row1      = r2_ff;
   assign cof       = cof_ff;

endmodule

### rtl/mi3_det.sv
module mi3_det import mi3_pkg::*; #(
   parameter int IW = IN_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [IW-1:0]          row1 [3],
   input  logic signed [2*IW:0]          cof [NUM_ELEM],
   output logic                          out_valid,
   output logic                          zero,
   output logic [3*IW+2:0]               dmag,
   output logic [2*IW+SCALE_SHIFT:0]     num [NUM_ELEM],
   output logic                          neg [NUM_ELEM]
);

   localparam int CW = 2 * IW + 1;
   localparam int PW = IW + CW;
   localparam int DW = 3 * IW + 3;
   localparam int NW = CW + SCALE_SHIFT;

   logic                 v1_ff, v2_ff, v3_ff;
   logic signed [PW-1:0] dp_ff [3];
   logic signed [CW-1:0] cof_ff [NUM_ELEM];
   logic signed [DW-1:0] det_ff;
   logic [CW-1:0]        mag_ff [NUM_ELEM];
   logic                 aneg_ff [NUM_ELEM];
   logic                 zero_ff;
   logic [DW-1:0]        dmag_ff;
   logic [NW-1:0]        num_ff [NUM_ELEM];
   logic                 neg_ff [NUM_ELEM];
   logic                 dneg;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign dneg = det_ff[DW-1];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         dp_ff[i] <= PW'(row1[i]) * PW'(cof[i]);
      end
      cof_ff <= cof;
      det_ff <= DW'(dp_ff[0]) + DW'(dp_ff[1]) + DW'(dp_ff[2]);
      // adjugate is the transpose of the cofactor matrix
      for (int i = 0; i < NUM_ELEM; i++) begin
         aneg_ff[i] <= cof_ff[(i % 3) * 3 + i / 3][CW-1];
         mag_ff[i]  <= cof_ff[(i % 3) * 3 + i / 3][CW-1]
                       ? CW'(-cof_ff[(i % 3) * 3 + i / 3])
                       : CW'(cof_ff[(i % 3) * 3 + i / 3]);
      end
      zero_ff <= (det_ff == '0);
      dmag_ff <= dneg ? DW'(-det_ff) : DW'(det_ff);
      for (int i = 0; i < NUM_ELEM; i++) begin
         num_ff[i] <= {mag_ff[i], {SCALE_SHIFT{1'b0}}};
         neg_ff[i] <= aneg_ff[i] ^ dneg;
      end
   end

   assign out_valid = v3_ff;
   assign zero      = zero_ff;
   assign dmag      = dmag_ff;
   assign num       = num_ff;
   assign neg       = neg_ff;

endmodule

### rtl/mi3_div_lane.sv
module mi3_div_lane import mi3_pkg::*; #(
   parameter int IW = IN_WIDTH_DEF,
   parameter int OW = OUT_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic                        in_zero,
   input  logic                        in_neg,
   input  logic [2*IW+SCALE_SHIFT:0]   num,
   input  logic [3*IW+2:0]             dmag,
   output logic                        out_valid,
   output logic                        out_zero,
   output logic signed [OW-1:0]        quot,
   output logic                        sat
);

   localparam int NW = 2 * IW + 1 + SCALE_SHIFT;
   localparam int DW = 3 * IW + 3;
   localparam int RW = ((NW > DW + OW) ? NW : DW + OW) + 1;

   logic          v_ff    [OW+1];
   logic          z_ff    [OW+1];
   logic          n_ff    [OW+1];
   logic          ovf_ff  [OW+1];
   logic [RW-1:0] rem_ff  [OW+1];
   logic [DW-1:0] d_ff    [OW+1];
   logic [OW-1:0] q_ff    [OW+1];
   logic          vo_ff, zo_ff, so_ff;
   logic [OW-1:0] quot_ff;
   logic [OW-1:0] lim;
   logic [OW-1:0] qm;
   logic          over;

   // entry stage: quotient of 2^OW or more cannot fit
   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else       v_ff[0] <= in_valid;
   end

   always_ff @(posedge clock) begin
      z_ff[0]   <= in_zero;
      n_ff[0]   <= in_neg;
      ovf_ff[0] <= RW'(num) >= (RW'(dmag) << OW);
      rem_ff[0] <= RW'(num);
      d_ff[0]   <= dmag;
      q_ff[0]   <= '0;
   end

   // one quotient bit per stage, most significant first
   for (genvar s = 1; s <= OW; s++) begin : g_stage
      logic [RW-1:0] t;
      logic          ge;
      assign t  = RW'(d_ff[s-1]) << (OW - s);
      assign ge = rem_ff[s-1] >= t;

      always_ff @(posedge clock) begin
         if (reset) v_ff[s] <= 1'b0;
         else       v_ff[s] <= v_ff[s-1];
      end

      always_ff @(posedge clock) begin
         z_ff[s]   <= z_ff[s-1];
         n_ff[s]   <= n_ff[s-1];
         ovf_ff[s] <= ovf_ff[s-1];
         d_ff[s]   <= d_ff[s-1];
         rem_ff[s] <= ge ? rem_ff[s-1] - t : rem_ff[s-1];
         q_ff[s]   <= q_ff[s-1] | (ge ? (OW'(1) << (OW - s)) : '0);
      end
   end

   assign lim  = n_ff[OW] ? (OW'(1) << (OW - 1)) : ((OW'(1) << (OW - 1)) - OW'(1));
   assign over = ovf_ff[OW] || (q_ff[OW] > lim);
   assign qm   = over ? lim : q_ff[OW];

   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else       vo_ff <= v_ff[OW];
   end

   always_ff @(posedge clock) begin
      zo_ff   <= z_ff[OW];
      so_ff   <= !z_ff[OW] && over;
      quot_ff <= z_ff[OW] ? '0 : (n_ff[OW] ? OW'(-qm) : qm);
   end

   assign out_valid = vo_ff;
   assign out_zero  = zo_ff;
   assign quot      = quot_ff;
   assign sat       = so_ff;

endmodule

### rtl/matrix_inverse_3x3.sv
// 3x3 matrix inverse by the adjugate. One request may be issued every clock
// (busy is never raised); its result appears on the rsp_ ports for one cycle
// with rsp_valid, after the cofactor products, the determinant and magnitude
// preparation, then the quotient bits, most significant first, in nine parallel
// restoring dividers with an entry and a saturation stage. The receiver cannot
// stall the pipeline, so results must be captured when rsp_valid is high. A zero
// determinant gives rsp_singular with all elements zero.
module matrix_inverse_3x3 import mi3_pkg::*; #(
   parameter int IN_WIDTH  = IN_WIDTH_DEF,
   parameter int OUT_WIDTH = OUT_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [IN_WIDTH-1:0]  req_a11,
   input  logic signed [IN_WIDTH-1:0]  req_a12,
   input  logic signed [IN_WIDTH-1:0]  req_a13,
   input  logic signed [IN_WIDTH-1:0]  req_a21,
   input  logic signed [IN_WIDTH-1:0]  req_a22,
   input  logic signed [IN_WIDTH-1:0]  req_a23,
   input  logic signed [IN_WIDTH-1:0]  req_a31,
   input  logic signed [IN_WIDTH-1:0]  req_a32,
   input  logic signed [IN_WIDTH-1:0]  req_a33,
   output logic                        rsp_valid,
   output logic signed [OUT_WIDTH-1:0] rsp_inv11,
   output logic signed [OUT_WIDTH-1:0] rsp_inv12,
   output logic signed [OUT_WIDTH-1:0] rsp_inv13,
   output logic signed [OUT_WIDTH-1:0] rsp_inv21,
   output logic signed [OUT_WIDTH-1:0] rsp_inv22,
   output logic signed [OUT_WIDTH-1:0] rsp_inv23,
   output logic signed [OUT_WIDTH-1:0] rsp_inv31,
   output logic signed [OUT_WIDTH-1:0] rsp_inv32,
   output logic signed [OUT_WIDTH-1:0] rsp_inv33,
   output logic                        rsp_singular,
   output logic                        rsp_saturated
);

   localparam int IW  = IN_WIDTH;
   localparam int OW  = OUT_WIDTH;
   localparam int LAT = COF_LATENCY + DET_LATENCY + OW + 2;

   logic signed [IW-1:0]        a [NUM_ELEM];
   logic                        cof_valid, det_valid, det_zero;
   logic signed [IW-1:0]        row1 [3];
   logic signed [2*IW:0]        cof [NUM_ELEM];
   logic [3*IW+2:0]             dmag;
   logic [2*IW+SCALE_SHIFT:0]   num [NUM_ELEM];
   logic                        neg [NUM_ELEM];
   logic                        lane_valid [NUM_ELEM];
   logic                        lane_zero [NUM_ELEM];
   logic signed [OW-1:0]        quot [NUM_ELEM];
   logic [NUM_ELEM-1:0]         sat;

   assign busy = 1'b0;

   assign a[0] = req_a11;  assign a[1] = req_a12;  assign a[2] = req_a13;
   assign a[3] = req_a21;  assign a[4] = req_a22;  assign a[5] = req_a23;
   assign a[6] = req_a31;  assign a[7] = req_a32;  assign a[8] = req_a33;

   mi3_cofactor #(.IW(IW)) u_cof (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .a         (a),
      .out_valid (cof_valid),
      .row1      (row1),
      .cof       (cof)
   );

   mi3_det #(.IW(IW)) u_det (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cof_valid),
      .row1      (row1),
      .cof       (cof),
      .out_valid (det_valid),
      .zero      (det_zero),
      .dmag      (dmag),
      .num       (num),
      .neg       (neg)
   );

   for (genvar i = 0; i < NUM_ELEM; i++) begin : g_lane
      mi3_div_lane #(.IW(IW), .OW(OW)) u_lane (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (det_valid),
         .in_zero   (det_zero),
         .in_neg    (neg[i]),
         .num       (num[i]),
         .dmag      (dmag),
         .out_valid (lane_valid[i]),
         .out_zero  (lane_zero[i]),
         .quot      (quot[i]),
         .sat       (sat[i])
      );
   end

   assign rsp_valid     = lane_valid[0] && lane_valid[NUM_ELEM-1];
   assign rsp_singular  = lane_zero[0];
   assign rsp_saturated = |sat;
   assign rsp_inv11 = quot[0];  assign rsp_inv12 = quot[1];  assign rsp_inv13 = quot[2];
   assign rsp_inv21 = quot[3];  assign rsp_inv22 = quot[4];  assign rsp_inv23 = quot[5];
   assign rsp_inv31 = quot[6];  assign rsp_inv32 = quot[7];  assign rsp_inv33 = quot[8];

`ifndef SYNTH
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LAT rsp_valid)
      else $error("request did not produce a response at fixed latency");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT))
      else $error("response without a matching request");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> (!rsp_saturated && rsp_inv11 == '0
         && rsp_inv22 == '0 && rsp_inv33 == '0 && rsp_inv13 == '0))
      else $error("singular response with nonzero elements or saturation");
`endif

endmodule

### test/tb_matrix_inverse_3x3.sv
`timescale 1ns / 1ps

module tb_matrix_inverse_3x3;
   import mi3_pkg::*;

   localparam int IW = IN_WIDTH_DEF;
   localparam int OW = OUT_WIDTH_DEF;
   localparam int PIPE_CYCLES = OW + 7;
   localparam int CYCLE_LIMIT = 400000;

   typedef logic signed [IW-1:0] elem_t;

   typedef struct {
      logic signed [OW-1:0] inv [NUM_ELEM];
      logic                 singular;
      logic                 saturated;
   } inverse_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   elem_t req_a [NUM_ELEM] = '{default: '0};
   logic rsp_valid, rsp_singular, rsp_saturated;
   logic signed [OW-1:0] rsp_inv [NUM_ELEM];

   inverse_t pending_inverses [$];
   int errors = 0;
   int cycles = 0;
   int idle_pct = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   matrix_inverse_3x3 dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a11(req_a[0]), .req_a12(req_a[1]), .req_a13(req_a[2]),
      .req_a21(req_a[3]), .req_a22(req_a[4]), .req_a23(req_a[5]),
      .req_a31(req_a[6]), .req_a32(req_a[7]), .req_a33(req_a[8]),
      .rsp_valid(rsp_valid),
      .rsp_inv11(rsp_inv[0]), .rsp_inv12(rsp_inv[1]), .rsp_inv13(rsp_inv[2]),
      .rsp_inv21(rsp_inv[3]), .rsp_inv22(rsp_inv[4]), .rsp_inv23(rsp_inv[5]),
      .rsp_inv31(rsp_inv[6]), .rsp_inv32(rsp_inv[7]), .rsp_inv33(rsp_inv[8]),
      .rsp_singular(rsp_singular), .rsp_saturated(rsp_saturated)
   );

   function automatic inverse_t adjugate_inverse(input elem_t m [NUM_ELEM]);
      inverse_t r;
      longint a [NUM_ELEM];
      longint cof [NUM_ELEM];
      longint adj, det;
      logic [127:0] dmag, num, quo, lim;
      logic neg;
      for (int i = 0; i < NUM_ELEM; i++) a[i] = longint'(m[i]);
      cof[0] = a[4] * a[8] - a[5] * a[7];
      cof[1] = a[5] * a[6] - a[3] * a[8];
      cof[2] = a[3] * a[7] - a[4] * a[6];
      cof[3] = a[2] * a[7] - a[1] * a[8];
      cof[4] = a[0] * a[8] - a[2] * a[6];
      cof[5] = a[1] * a[6] - a[0] * a[7];
      cof[6] = a[1] * a[5] - a[2] * a[4];
      cof[7] = a[2] * a[3] - a[0] * a[5];
      cof[8] = a[0] * a[4] - a[1] * a[3];
      det = a[0] * cof[0] + a[1] * cof[1] + a[2] * cof[2];
      r.singular = (det == 0);
      r.saturated = 1'b0;
      for (int i = 0; i < NUM_ELEM; i++) r.inv[i] = '0;
      if (det == 0) return r;
      dmag = (det < 0) ? 128'(-det) : 128'(det);
      for (int i = 0; i < NUM_ELEM; i++) begin
         adj = cof[(i % 3) * 3 + i / 3];
         neg = (adj < 0) != (det < 0);
         num = ((adj < 0) ? 128'(-adj) : 128'(adj)) << SCALE_SHIFT;
         quo = num / dmag;
         lim = neg ? (128'(1) << (OW - 1)) : ((128'(1) << (OW - 1)) - 1);
         if (quo > lim) begin
            quo = lim;
            r.saturated = 1'b1;
         end
         r.inv[i] = neg ? OW'(-quo) : OW'(quo);
      end
      return r;
   endfunction

   // results come back in request order; the receiver never stalls
   always @(posedge clock) begin
      inverse_t want;
      if (!reset && rsp_valid) begin
         if (pending_inverses.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual inv11=%0d",
                     $time, rsp_inv[0]);
            errors++;
         end else begin
            want = pending_inverses.pop_front();
            for (int i = 0; i < NUM_ELEM; i++)
               if (rsp_inv[i] !== want.inv[i]) begin
                  $display("%0t: inv%0d%0d expected %0d actual %0d", $time,
                           i / 3 + 1, i % 3 + 1, want.inv[i], rsp_inv[i]);
                  errors++;
               end
            if (rsp_singular !== want.singular) begin
               $display("%0t: singular expected %0b actual %0b", $time,
                        want.singular, rsp_singular);
               errors++;
            end
            if (rsp_saturated !== want.saturated) begin
               $display("%0t: saturated expected %0b actual %0b", $time,
                        want.saturated, rsp_saturated);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL matrix_inverse_3x3");
         $finish;
      end
   end

   task automatic send_request(input elem_t m [NUM_ELEM]);
      for (int i = 0; i < NUM_ELEM; i++) req_a[i] <= m[i];
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_inverses.push_back(adjugate_inverse(m));
      // each following cycle is idle with probability idle_pct percent
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain_pipeline();
      start <= 1'b0;
      @(posedge clock);
      while (pending_inverses.size() != 0) @(posedge clock);
   endtask

   function automatic elem_t pick_extreme();
      case ($urandom_range(4))
         0: return elem_t'(32767);
         1: return elem_t'(-32768);
         2: return elem_t'(0);
         3: return elem_t'(1);
         default: return elem_t'(-1);
      endcase
   endfunction

   function automatic void random_matrix(output elem_t m [NUM_ELEM]);
      int mode;
      mode = $urandom_range(99);
      for (int i = 0; i < NUM_ELEM; i++) begin
         if (mode < 40) m[i] = elem_t'($urandom);
         else if (mode < 60) m[i] = elem_t'(elem_t'($urandom_range(0, 1023)) - 512
                                    + ((i % 4 == 0) ? elem_t'(4096) : elem_t'(0)));
         else if (mode < 75) m[i] = elem_t'(elem_t'($urandom_range(0, 16)) - 8);
         else if (mode < 88) m[i] = elem_t'($urandom);
         else m[i] = pick_extreme();
      end
      // dependent rows give a singular matrix
      if (mode >= 75 && mode < 88)
         for (int c = 0; c < 3; c++) m[6 + c] = m[$urandom_range(1) * 3 + c];
   endfunction

   task automatic test_directed();
      elem_t m [NUM_ELEM];
      idle_pct = 0;
      m = '{4096, 0, 0, 0, 4096, 0, 0, 0, 4096};        send_request(m);
      m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                 send_request(m);
      m = '{32767, 0, 0, 0, 32767, 0, 0, 0, 32767};     send_request(m);
      m = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};  send_request(m);
      m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                 send_request(m);
      m = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};                send_request(m);
      m = '{0, -32768, 0, 32767, 0, 0, 0, 0, -32768};   send_request(m);
      m = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
      send_request(m);
      m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
      send_request(m);
      m = '{4096, 8192, 12288, 16384, 20480, 24576, 28672, 32767, -32768};
      send_request(m);
      m = '{2, 1, 0, 1, 2, 1, 0, 1, 2};                 send_request(m);
      m = '{-32768, 32767, 0, 32767, -32768, 32767, 0, 32767, -32768};
      send_request(m);
      m = '{4096, 4096, 0, 4096, 4096, 0, 0, 0, 4096};  send_request(m);
      m = '{0, 0, 4096, 0, 4096, 0, 4096, 0, 0};        send_request(m);
      drain_pipeline();
   endtask

   task automatic test_random(input int count, input int pct);
      elem_t m [NUM_ELEM];
      idle_pct = pct;
      repeat (count) begin
         random_matrix(m);
         send_request(m);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(150, 0);
      test_random(150, 61);
      drain_pipeline();                       // full pause, then resume
      test_random(150, 24);
      test_random(150, 0);
      drain_pipeline();
      repeat (PIPE_CYCLES + 10) @(posedge clock);
      if (errors == 0) $display("PASS matrix_inverse_3x3");
      else $display("FAIL matrix_inverse_3x3");
      $finish;
   end

endmodule
